FILE: hdl/ordered_value_list_macros.svh
// ordered_value_list_macros.svh: assertion macros for the ordered value list.
// Included by the modules that carry checks; depends on nothing.
`ifndef ORDERED_VALUE_LIST_MACROS_SVH
`define ORDERED_VALUE_LIST_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define OVL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ordered_value_list: check failed");

// Next-cycle implication, disabled while reset is asserted
`define OVL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ordered_value_list: check failed");

`else

`define OVL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define OVL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/ovl_pkg.sv
// ovl_pkg: widths, request and status codes, and shared types of the
// ordered value list. Depends on nothing.
package ovl_pkg;

  // Storage sizing
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths
  localparam int REQ_W  = 2;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int POS_W  = 4;
  localparam int ECNT_W = 5;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_REVERSE = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

  // Access to the entry store from the sequencer
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_addr;
  } store_req_t;

  // Finished result handed to the output stage
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [ECNT_W-1:0] entry_count;
  } rsp_t;

  // Slot index to the 4-bit position field (masked or zero-extended)
  function automatic logic [POS_W-1:0] pos_field(logic [IDX_W-1:0] idx);
    logic [POS_W+IDX_W-1:0] wide;
    wide = {{POS_W{1'b0}}, idx};
    return wide[POS_W-1:0];
  endfunction

  // Fill count to the 5-bit entry_count field (masked or zero-extended)
  function automatic logic [ECNT_W-1:0] cnt_field(logic [CNT_W-1:0] cnt);
    logic [ECNT_W+CNT_W-1:0] wide;
    wide = {{ECNT_W{1'b0}}, cnt};
    return wide[ECNT_W-1:0];
  endfunction

endpackage

FILE: hdl/ovl_chan_if.sv
// ovl_chan_if: valid/ready channel interfaces for requests and results.
// Depends on ovl_pkg.
interface ovl_req_if;
  logic                              valid;
  logic                              ready;
  logic [ovl_pkg::REQ_W-1:0]         req_type;
  logic signed [ovl_pkg::VAL_W-1:0]  value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface ovl_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ovl_pkg::STAT_W-1:0]  status;
  logic [ovl_pkg::POS_W-1:0]   position;
  logic [ovl_pkg::ECNT_W-1:0]  entry_count;

  modport source (output valid, output status, output position, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input position, input entry_count,
                  output ready);
endinterface

FILE: hdl/ovl_store.sv
// ovl_store: entry storage, one write port and one registered read port.
// Depends on ovl_pkg.
module ovl_store (
  input  logic                      clk,
  input  ovl_pkg::store_req_t       req,
  output logic [ovl_pkg::VAL_W-1:0] rd_data
);

  logic [ovl_pkg::VAL_W-1:0] mem [ovl_pkg::CAPACITY];
  logic [ovl_pkg::VAL_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read port; old data on a same-address write
  always_ff @(posedge clk) begin
    rd_data_r <= mem[req.rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/ovl_ctrl.sv
// ovl_ctrl: request sequencer with the shared compare and slot arithmetic.
// Depends on ovl_pkg, ovl_chan_if and ordered_value_list_macros.svh.
`include "ordered_value_list_macros.svh"

module ovl_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  ovl_req_if.sink                   in_req,
  output ovl_pkg::store_req_t       st_req,
  input  logic [ovl_pkg::VAL_W-1:0] rd_data,
  output logic                      res_valid,
  input  logic                      res_ready,
  output ovl_pkg::rsp_t             res
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHUP,
    ST_INS0,
    ST_SCAN,
    ST_SHDN,
    ST_DONE
  } state_t;

  state_t                            state_r, state_nxt;
  logic [ovl_pkg::REQ_W-1:0]         req_r, req_nxt;
  logic [ovl_pkg::VAL_W-1:0]         value_r, value_nxt;
  logic [ovl_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic                              rev_r, rev_nxt;
  logic [ovl_pkg::IDX_W-1:0]         pos_r, pos_nxt;
  logic [ovl_pkg::IDX_W-1:0]         ptr_r, ptr_nxt;
  logic [ovl_pkg::STAT_W-1:0]        status_r, status_nxt;
  logic [ovl_pkg::POS_W-1:0]         position_r, position_nxt;

  logic [ovl_pkg::IDX_W-1:0]         cur_slot;
  logic [ovl_pkg::IDX_W-1:0]         next_slot;
  logic [ovl_pkg::IDX_W-1:0]         last_slot;
  logic                              match;

  // Physical slot of a logical position, front at slot zero or at the top
  function automatic logic [ovl_pkg::IDX_W-1:0] slot_of(
    logic                      rev,
    logic [ovl_pkg::CNT_W-1:0] cnt,
    logic [ovl_pkg::CNT_W-1:0] p
  );
    logic [ovl_pkg::CNT_W-1:0] s;
    s = rev ? (cnt - ovl_pkg::CNT_W'(1) - p) : p;
    return s[ovl_pkg::IDX_W-1:0];
  endfunction

  // Shared slot arithmetic and the one comparator
  assign cur_slot  = slot_of(rev_r, count_r, ovl_pkg::CNT_W'(pos_r));
  assign next_slot = slot_of(rev_r, count_r, ovl_pkg::CNT_W'(pos_r) + ovl_pkg::CNT_W'(1));
  assign last_slot = ovl_pkg::IDX_W'(count_r - ovl_pkg::CNT_W'(1));
  assign match     = (rd_data == value_r);

  assign in_req.ready = (state_r == ST_IDLE);
  assign res_valid    = (state_r == ST_DONE);
  assign res          = '{status: status_r, position: position_r,
                          entry_count: ovl_pkg::cnt_field(count_r)};

  // Sequencer next-state and store access
  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    value_nxt    = value_r;
    count_nxt    = count_r;
    rev_nxt      = rev_r;
    pos_nxt      = pos_r;
    ptr_nxt      = ptr_r;
    status_nxt   = status_r;
    position_nxt = position_r;
    st_req       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          req_nxt      = in_req.req_type;
          value_nxt    = in_req.value;
          pos_nxt      = '0;
          status_nxt   = ovl_pkg::STAT_DONE;
          position_nxt = '0;
          case (in_req.req_type) inside
            ovl_pkg::REQ_INSERT: begin
              if (count_r == ovl_pkg::CNT_W'(ovl_pkg::CAPACITY)) begin
                status_nxt = ovl_pkg::STAT_FULL;
                state_nxt  = ST_DONE;
              end else if (!rev_r || count_r == '0) begin
                // back is at the top, or the list is empty
                st_req.wr_en   = 1'b1;
                st_req.wr_addr = rev_r ? '0 : count_r[ovl_pkg::IDX_W-1:0];
                st_req.wr_data = in_req.value;
                count_nxt      = count_r + ovl_pkg::CNT_W'(1);
                state_nxt      = ST_DONE;
              end else begin
                // back is slot zero: move every entry up one slot first
                ptr_nxt        = last_slot;
                st_req.rd_addr = last_slot;
                state_nxt      = ST_SHUP;
              end
            end
            ovl_pkg::REQ_DELETE, ovl_pkg::REQ_SEARCH: begin
              if (count_r == '0) begin
                status_nxt = ovl_pkg::STAT_NOTFOUND;
                state_nxt  = ST_DONE;
              end else begin
                st_req.rd_addr = slot_of(rev_r, count_r, '0);
                state_nxt      = ST_SCAN;
              end
            end
            default: begin
              rev_nxt   = !rev_r;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      // entries[ptr] is on the read port; copy it one slot up
      ST_SHUP: begin
        st_req.wr_en   = 1'b1;
        st_req.wr_addr = ptr_r + ovl_pkg::IDX_W'(1);
        st_req.wr_data = rd_data;
        if (ptr_r == '0) begin
          state_nxt = ST_INS0;
        end else begin
          ptr_nxt        = ptr_r - ovl_pkg::IDX_W'(1);
          st_req.rd_addr = ptr_r - ovl_pkg::IDX_W'(1);
        end
      end

      // slot zero is free: place the new back entry
      ST_INS0: begin
        st_req.wr_en   = 1'b1;
        st_req.wr_addr = '0;
        st_req.wr_data = value_r;
        count_nxt      = count_r + ovl_pkg::CNT_W'(1);
        state_nxt      = ST_DONE;
      end

      // compare the entry at logical position pos
      ST_SCAN: begin
        if (match) begin
          if (req_r == ovl_pkg::REQ_SEARCH) begin
            position_nxt = ovl_pkg::pos_field(pos_r);
            state_nxt    = ST_DONE;
          end else if (ovl_pkg::CNT_W'(cur_slot) + ovl_pkg::CNT_W'(1) < count_r) begin
            ptr_nxt        = cur_slot;
            st_req.rd_addr = cur_slot + ovl_pkg::IDX_W'(1);
            state_nxt      = ST_SHDN;
          end else begin
            // match in the top slot: nothing to close up
            count_nxt = count_r - ovl_pkg::CNT_W'(1);
            state_nxt = ST_DONE;
          end
        end else if (ovl_pkg::CNT_W'(pos_r) + ovl_pkg::CNT_W'(1) == count_r) begin
          status_nxt = ovl_pkg::STAT_NOTFOUND;
          state_nxt  = ST_DONE;
        end else begin
          pos_nxt        = pos_r + ovl_pkg::IDX_W'(1);
          st_req.rd_addr = next_slot;
        end
      end

      // entries[ptr+1] is on the read port; close the gap at ptr
      ST_SHDN: begin
        st_req.wr_en   = 1'b1;
        st_req.wr_addr = ptr_r;
        st_req.wr_data = rd_data;
        if (ovl_pkg::CNT_W'(ptr_r) + ovl_pkg::CNT_W'(2) < count_r) begin
          ptr_nxt        = ptr_r + ovl_pkg::IDX_W'(1);
          st_req.rd_addr = ovl_pkg::IDX_W'(ovl_pkg::CNT_W'(ptr_r) + ovl_pkg::CNT_W'(2));
        end else begin
          count_nxt = count_r - ovl_pkg::CNT_W'(1);
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      rev_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
    end
    req_r      <= req_nxt;
    value_r    <= value_nxt;
    pos_r      <= pos_nxt;
    ptr_r      <= ptr_nxt;
    status_r   <= status_nxt;
    position_r <= position_nxt;
  end

  // Checks
  `OVL_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1,
                  count_r <= ovl_pkg::CNT_W'(ovl_pkg::CAPACITY))
  `OVL_ASSERT_IMP(a_full_status, clk, rst_n,
                  res_valid && res.status == ovl_pkg::STAT_FULL,
                  count_r == ovl_pkg::CNT_W'(ovl_pkg::CAPACITY))
  `OVL_ASSERT_NXT(a_scan_no_write, clk, rst_n,
                  state_r == ST_SCAN && !match,
                  count_r == $past(count_r))

endmodule

FILE: hdl/ordered_value_list.sv
// ordered_value_list: top level, sequencer plus entry store plus result register.
// Depends on ovl_pkg, ovl_chan_if, ovl_store and ovl_ctrl.
//
//   channel   port     dir  payload
//   request   in_req   in   req_type[1:0], value[31:0] signed
//   result    out_rsp  out  status[1:0], position[3:0], entry_count[4:0]
//
// One request at a time; the store has a single registered read port and one
// comparator. Reverse, full insert, empty search and forward append go
// straight to the result register; search scans from the front; delete scans,
// then closes the gap; reversed append first moves every entry up one slot.
// Reset is synchronous; the store is not cleared. A stalled result sits in
// the output register while the next request is taken.
module ordered_value_list (
  input  logic      clk,
  input  logic      rst_n,
  ovl_req_if.sink   in_req,
  ovl_rsp_if.source out_rsp
);

  ovl_pkg::store_req_t        st_req;
  logic [ovl_pkg::VAL_W-1:0]  rd_data;
  logic                       res_valid;
  logic                       res_ready;
  ovl_pkg::rsp_t              res;

  logic                       out_valid_r;
  ovl_pkg::rsp_t              out_data_r;

  ovl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .st_req    (st_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  ovl_store u_store (
    .clk     (clk),
    .req     (st_req),
    .rd_data (rd_data)
  );

  // Result register: loads when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_data_r.status;
  assign out_rsp.position    = out_data_r.position;
  assign out_rsp.entry_count = out_data_r.entry_count;

endmodule
